### src/uqa_pkg.sv
// Shared types, codes and constants of the user quota authorizer.
`timescale 1ns / 1ps

package uqa_pkg;

    localparam int MAX_USERS_DEF    = 64;
    localparam int NUM_SERVICES_DEF = 3;

    localparam int CFG_W    = 7;
    localparam int ID_W     = 22;
    localparam int QTY_W    = 31;
    localparam int SVC_W    = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int REQ_W    = 32;
    localparam int TOT_W    = 48;

    localparam logic [CFG_W-1:0] MAX_USERS_RESET = 7'd64;

    typedef enum logic
    {
        CMD_REGISTER = 1'b0,
        CMD_REQUEST  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_REGISTERED = 3'd0,
        ST_FULL       = 3'd1,
        ST_AUTHORIZED = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_NO_CREDIT  = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_DONE
    } eng_state_t;

    typedef struct packed
    {
        logic [ID_W-1:0]  id;
        logic [QTY_W-1:0] limit;
        logic [QTY_W-1:0] consumed;
    } entry_t;

    typedef struct packed
    {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } result_t;

endpackage

### src/user_quota_authorizer_core.sv
// A register item, or a request while the table is empty, gives its result from the
// sequencer's result register and then the output register; a request scans the table
// until it matches an entry or passes the last user, as the scan reads one table entry per cycle.
// Throughput: one item at a time; the next is accepted once the result leaves the sequencer.
// Reset sets max_users to 64 and clears the user count and service totals; table
// contents are not cleared and are never read before they are written.
`timescale 1ns / 1ps

module user_quota_authorizer_core import uqa_pkg::*; #(
    parameter int MAX_USERS    = MAX_USERS_DEF,
    parameter int NUM_SERVICES = NUM_SERVICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic [ID_W-1:0]     user_id,
    input  logic [QTY_W-1:0]    quantity,
    input  logic [SVC_W-1:0]    service_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot
);

    logic [CFG_W-1:0] max_users_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg, out_res_next;
    logic             res_valid;
    logic             res_take;
    result_t          res;

    uqa_engine #(
        .MAX_USERS    (MAX_USERS),
        .NUM_SERVICES (NUM_SERVICES)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .max_users        (max_users_reg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_cmd           (cmd_t'(cmd)),
        .in_user_id       (user_id),
        .in_quantity      (quantity),
        .in_service_index (service_index),
        .res_valid        (res_valid),
        .res_take         (res_take),
        .res              (res)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_users_reg <= MAX_USERS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_users_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign slot      = out_res_reg.slot;

endmodule

### src/uqa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module uqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/uqa_engine.sv
// Sequencer that registers users and scans the quota table one entry per cycle.
`timescale 1ns / 1ps

module uqa_engine import uqa_pkg::*; #(
    parameter int MAX_USERS    = MAX_USERS_DEF,
    parameter int NUM_SERVICES = NUM_SERVICES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CFG_W-1:0]  max_users,
    input  logic              in_valid,
    output logic              in_stall,
    input  cmd_t              in_cmd,
    input  logic [ID_W-1:0]   in_user_id,
    input  logic [QTY_W-1:0]  in_quantity,
    input  logic [SVC_W-1:0]  in_service_index,
    output logic              res_valid,
    input  logic              res_take,
    output result_t           res
);

    localparam int AW   = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int CW   = $clog2(MAX_USERS + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    eng_state_t        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     issue_reg, issue_next;
    logic [AW-1:0]     data_idx_reg, data_idx_next;
    logic              data_valid_reg, data_valid_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [QTY_W-1:0]  qty_reg, qty_next;
    logic [SVC_W-1:0]  svc_reg, svc_next;
    result_t           res_reg, res_next;
    logic [REQ_W-1:0]  svc_req_reg [NUM_SERVICES];
    logic [REQ_W-1:0]  svc_req_next [NUM_SERVICES];
    logic [TOT_W-1:0]  svc_total_reg [NUM_SERVICES];
    logic [TOT_W-1:0]  svc_total_next [NUM_SERVICES];

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    entry_t            ram_rdata;

    logic              accept;
    logic              full;
    logic              id_match;
    logic              last_entry;
    logic [QTY_W:0]    credit_sum;
    logic              over_limit;

    uqa_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_USERS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_reg),
        .rdata (ram_rdata)
    );

    assign accept     = in_valid && !in_stall;
    assign full       = (CMPW'(count_reg) >= CMPW'(max_users)) ||
                        (CMPW'(count_reg) >= CMPW'(MAX_USERS));
    assign id_match   = data_valid_reg && (ram_rdata.id == id_reg);
    assign last_entry = ((CW + 1)'(data_idx_reg) + (CW + 1)'(1)) == (CW + 1)'(count_reg);
    assign credit_sum = {1'b0, ram_rdata.consumed} + {1'b0, qty_reg};
    assign over_limit = credit_sum > {1'b0, ram_rdata.limit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            data_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_SERVICES; k++)
            begin
                svc_req_reg[k]   <= '0;
                svc_total_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            data_valid_reg <= data_valid_next;
            for (int k = 0; k < NUM_SERVICES; k++)
            begin
                svc_req_reg[k]   <= svc_req_next[k];
                svc_total_reg[k] <= svc_total_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg    <= issue_next;
        data_idx_reg <= data_idx_next;
        id_reg       <= id_next;
        qty_reg      <= qty_next;
        svc_reg      <= svc_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        data_idx_next   = data_idx_reg;
        data_valid_next = data_valid_reg;
        id_next         = id_reg;
        qty_next        = qty_reg;
        svc_next        = svc_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = '{id: in_user_id, limit: in_quantity, consumed: '0};
        for (int k = 0; k < NUM_SERVICES; k++)
        begin
            svc_req_next[k]   = svc_req_reg[k];
            svc_total_next[k] = svc_total_reg[k];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next  = in_user_id;
                    qty_next = in_quantity;
                    svc_next = in_service_index;
                    if (in_cmd == CMD_REGISTER)
                    begin
                        state_next = S_DONE;
                        if (full)
                        begin
                            res_next = '{status: ST_FULL, slot: '0};
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            res_next   = '{status: ST_REGISTERED,
                                           slot: SLOT_W'(count_reg[AW-1:0])};
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DONE;
                        res_next   = '{status: ST_UNKNOWN, slot: '0};
                    end
                    else
                    begin
                        state_next      = S_SCAN;
                        issue_next      = '0;
                        data_valid_next = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                issue_next      = issue_reg + AW'(1);
                data_idx_next   = issue_reg;
                data_valid_next = 1'b1;
                if (id_match)
                begin
                    state_next      = S_DONE;
                    data_valid_next = 1'b0;
                    if (over_limit)
                    begin
                        res_next = '{status: ST_NO_CREDIT, slot: SLOT_W'(data_idx_reg)};
                    end
                    else
                    begin
                        res_next  = '{status: ST_AUTHORIZED, slot: SLOT_W'(data_idx_reg)};
                        ram_we    = 1'b1;
                        ram_waddr = data_idx_reg;
                        ram_wdata = '{id: ram_rdata.id, limit: ram_rdata.limit,
                                      consumed: credit_sum[QTY_W-1:0]};
                        for (int k = 0; k < NUM_SERVICES; k++)
                        begin
                            if (int'(svc_reg) == k)
                            begin
                                svc_req_next[k]   = svc_req_reg[k] + REQ_W'(1);
                                svc_total_next[k] = svc_total_reg[k] + TOT_W'(qty_reg);
                            end
                        end
                    end
                end
                else if (data_valid_reg && last_entry)
                begin
                    state_next      = S_DONE;
                    data_valid_next = 1'b0;
                    res_next        = '{status: ST_UNKNOWN, slot: '0};
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (CMPW + 1)'(count_reg) <= (CMPW + 1)'(MAX_USERS))
        else $error("User count is above the table depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && data_valid_reg) |->
        ((CW + 1)'(data_idx_reg) < (CW + 1)'(count_reg)))
        else $error("Scan compared an entry beyond the registered users.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_cmd == CMD_REGISTER && !full) |=>
        (count_reg == $past(count_reg) + CW'(1)))
        else $error("Registration did not advance the user count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status == ST_UNKNOWN || res.status == ST_FULL)) |->
        (res.slot == '0))
        else $error("Refused item carries a nonzero slot.");

endmodule
